### sv/qgsv_pkg.sv
// ============================================================================
// qgsv_pkg: shared types and constants for the state vector gate unit
// Holds the item kinds, status codes, the sequencer state type and the
// fixed-point helpers used by the gate datapath.
// ============================================================================
package qgsv_pkg;

	localparam int MAX_QUBITS = 10;
	localparam int DEPTH      = 1 << MAX_QUBITS;
	localparam int AW         = MAX_QUBITS;
	localparam int QW         = 4;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_GATE  = 2'd2,
		KIND_CGATE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_SAMEQB  = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDLO,
		S_RDHI,
		S_MUL,
		S_SUM,
		S_WRLO,
		S_WRHI,
		S_DONE
	} seq_state_t;

	// Saturate a sum of four rounded Q.15 terms to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [19:0] s);
		logic signed [15:0] r;
		if (s > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (s < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

	// Round a Q2.30 product to Q.15 with floor after adding one half.
	function automatic logic signed [17:0] rnd15(input logic signed [31:0] p);
		logic signed [32:0] b;
		b = {p[31], p} + 33'sd16384;
		return b[32:15];
	endfunction

endpackage

### sv/qubit_gate_state_vector_update.sv
// ============================================================================
// qubit_gate_state_vector_update: state vector store with 2x2 gate engine
// Holds 2^n Q1.15 complex amplitudes in one synchronous memory and applies
// writes, reads and (controlled) single-qubit gates one item at a time.
//
//   channel  | direction | contents
//   s_axis   | in        | kind in tuser, the other fields in tdata
//   m_axis   | out       | read_re, read_im, status in tdata
//   cfg      | in        | qubits_in_use, written by cfg_we
//
// A gate with valid qubit indices walks all 2^n indices and steps through each
// pair it updates (read low, read high, multiply, sum, write low, write high).
// Reset clears the sequencer and sets the qubit count to ten; amplitudes are
// undefined until written. A stalled result holds in the output register and
// blocks the next item.
// ============================================================================
module qubit_gate_state_vector_update (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: amp_index, amp_re, amp_im, target_qubit, control_qubit,
	// entry_00, entry_01, entry_10, entry_11 (178 bits, padded to 184)
	input  logic [183:0] s_axis_tdata,
	// tuser: kind
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: read_re, read_im, status (34 bits, padded to 40)
	output logic [39:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata
);
	import qgsv_pkg::*;

	seq_state_t state_q, state_d;
	logic [3:0] nq_q;
	logic [QW-1:0] n_eff;
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q, lo_q;
	logic [AW-1:0] raddr, waddr, idx_q, mask;
	logic [31:0] wdata;
	logic re, we;
	kind_t kind_q;
	logic [AW-1:0] aidx_q;
	logic [31:0] amp_q;
	logic [QW-1:0] tq_q, cq_q;
	logic [31:0] e00_q, e01_q, e10_q, e11_q;
	logic [15:0] rre_q, rim_q;
	status_t st_q, st_chk;
	logic ovalid_q;
	logic [AW-1:0] tbit, cbit, hiidx;
	logic last, visit, mac_start;
	logic [31:0] new_lo, new_hi;
	logic accept;

	// Effective qubit count, clamped to one through MAX_QUBITS.
	always_comb begin
		if (nq_q == '0) begin
			n_eff = QW'(1);
		end else if (nq_q > QW'(MAX_QUBITS)) begin
			n_eff = QW'(MAX_QUBITS);
		end else begin
			n_eff = nq_q;
		end
		mask  = AW'((32'd1 << n_eff) - 32'd1);
		tbit  = AW'(32'd1 << tq_q);
		cbit  = (kind_q == KIND_CGATE) ? AW'(32'd1 << cq_q) : '0;
		hiidx = idx_q | tbit;
		last  = ((idx_q & mask) == mask);
		visit = ((idx_q & tbit) == '0) && ((idx_q & cbit) == cbit);
	end

	// Qubit index checks for gate items.
	always_comb begin
		if ((tq_q >= n_eff) || ((kind_q == KIND_CGATE) && (cq_q >= n_eff))) begin
			st_chk = ST_RANGE;
		end else if ((kind_q == KIND_CGATE) && (cq_q == tq_q)) begin
			st_chk = ST_SAMEQB;
		end else begin
			st_chk = ST_OK;
		end
	end

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nq_q <= 4'd10;
		end else if (cfg_we) begin
			nq_q <= cfg_wdata;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(s_axis_tuser);
			aidx_q <= s_axis_tdata[9:0];
			amp_q  <= {s_axis_tdata[25:10], s_axis_tdata[41:26]};
			tq_q   <= s_axis_tdata[45:42];
			cq_q   <= s_axis_tdata[49:46];
			e00_q  <= s_axis_tdata[81:50];
			e01_q  <= s_axis_tdata[113:82];
			e10_q  <= s_axis_tdata[145:114];
			e11_q  <= s_axis_tdata[177:146];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_RDLO;
			end
			S_RDLO: begin
				if (kind_q == KIND_WRITE || kind_q == KIND_READ) begin
					state_d = S_DONE;
				end else if (st_chk != ST_OK) begin
					state_d = S_DONE;
				end else if (visit) begin
					state_d = S_RDHI;
				end else if (last) begin
					state_d = S_DONE;
				end
			end
			S_RDHI: state_d = S_MUL;
			S_MUL:  state_d = S_SUM;
			S_SUM:  state_d = S_WRLO;
			S_WRLO: state_d = S_WRHI;
			S_WRHI: state_d = last ? S_DONE : S_RDLO;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		re = 1'b0;
		we = 1'b0;
		raddr = idx_q;
		waddr = idx_q;
		wdata = new_lo;
		mac_start = 1'b0;
		case (state_q)
			S_RDLO: begin
				if (kind_q == KIND_WRITE) begin
					we = 1'b1;
					waddr = aidx_q & mask;
					wdata = amp_q;
				end else if (kind_q == KIND_READ) begin
					re = 1'b1;
					raddr = aidx_q & mask;
				end else begin
					re = visit && (st_chk == ST_OK);
				end
			end
			S_RDHI: begin
				re = 1'b1;
				raddr = hiidx;
			end
			S_SUM:  mac_start = 1'b0;
			S_MUL:  mac_start = 1'b1;
			S_WRLO: we = 1'b1;
			S_WRHI: begin
				we = 1'b1;
				waddr = hiidx;
				wdata = new_hi;
			end
			default: re = 1'b0;
		endcase
	end

	// Amplitude memory, one synchronous port pair.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RDHI) lo_q <= rdata_q;
	end

	qgsv_mac u_mac (
		.clk    (clk),
		.start  (mac_start),
		.e00    (e00_q),
		.e01    (e01_q),
		.e10    (e10_q),
		.e11    (e11_q),
		.lo     (lo_q),
		.hi     (rdata_q),
		.new_lo (new_lo),
		.new_hi (new_hi)
	);

	// Sequencer, index counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) idx_q <= '0;
			else if ((state_q == S_RDLO && !visit) || state_q == S_WRHI) idx_q <= idx_q + 1'b1;
			if (state_q == S_DONE) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			rre_q <= (kind_q == KIND_READ) ? rdata_q[31:16] : '0;
			rim_q <= (kind_q == KIND_READ) ? rdata_q[15:0] : '0;
			st_q  <= (kind_q == KIND_GATE || kind_q == KIND_CGATE) ? st_chk : ST_OK;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {6'd0, st_q, rim_q, rre_q};

endmodule

### sv/qgsv_mac.sv
// ============================================================================
// qgsv_mac: butterfly arithmetic for one amplitude pair
// Forms the 16 real products in one registered stage, then rounds, sums and
// saturates both new amplitudes in the next.
// ============================================================================
module qgsv_mac (
	input  logic        clk,
	input  logic        start,
	input  logic [31:0] e00,
	input  logic [31:0] e01,
	input  logic [31:0] e10,
	input  logic [31:0] e11,
	input  logic [31:0] lo,
	input  logic [31:0] hi,
	output logic [31:0] new_lo,
	output logic [31:0] new_hi
);
	import qgsv_pkg::*;

	logic signed [31:0] p_s1 [16];
	logic signed [17:0] r [16];
	logic signed [19:0] s [4];
	logic [31:0] new_lo_q, new_hi_q;

	// Real products: for each row and column, ac, bd, ad, bc.
	always_ff @(posedge clk) begin
		if (start) begin
			p_s1[0]  <= $signed(e00[31:16]) * $signed(lo[31:16]);
			p_s1[1]  <= $signed(e00[15:0])  * $signed(lo[15:0]);
			p_s1[2]  <= $signed(e00[31:16]) * $signed(lo[15:0]);
			p_s1[3]  <= $signed(e00[15:0])  * $signed(lo[31:16]);
			p_s1[4]  <= $signed(e01[31:16]) * $signed(hi[31:16]);
			p_s1[5]  <= $signed(e01[15:0])  * $signed(hi[15:0]);
			p_s1[6]  <= $signed(e01[31:16]) * $signed(hi[15:0]);
			p_s1[7]  <= $signed(e01[15:0])  * $signed(hi[31:16]);
			p_s1[8]  <= $signed(e10[31:16]) * $signed(lo[31:16]);
			p_s1[9]  <= $signed(e10[15:0])  * $signed(lo[15:0]);
			p_s1[10] <= $signed(e10[31:16]) * $signed(lo[15:0]);
			p_s1[11] <= $signed(e10[15:0])  * $signed(lo[31:16]);
			p_s1[12] <= $signed(e11[31:16]) * $signed(hi[31:16]);
			p_s1[13] <= $signed(e11[15:0])  * $signed(hi[15:0]);
			p_s1[14] <= $signed(e11[31:16]) * $signed(hi[15:0]);
			p_s1[15] <= $signed(e11[15:0])  * $signed(hi[31:16]);
		end
	end

	// Round every product and combine into real and imaginary sums.
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			r[k] = rnd15(p_s1[k]);
		end
		s[0] = 20'(r[0]) - 20'(r[1]) + 20'(r[4]) - 20'(r[5]);
		s[1] = 20'(r[2]) + 20'(r[3]) + 20'(r[6]) + 20'(r[7]);
		s[2] = 20'(r[8]) - 20'(r[9]) + 20'(r[12]) - 20'(r[13]);
		s[3] = 20'(r[10]) + 20'(r[11]) + 20'(r[14]) + 20'(r[15]);
	end

	always_ff @(posedge clk) begin
		new_lo_q <= {sat16(s[0]), sat16(s[1])};
		new_hi_q <= {sat16(s[2]), sat16(s[3])};
	end

	assign new_lo = new_lo_q;
	assign new_hi = new_hi_q;

endmodule

### sim/tb_qubit_gate_state_vector_update.sv
// ============================================================================
// tb_qubit_gate_state_vector_update: self-checking bench for the gate unit
// Fills the low part of the amplitude store, then runs directed and random
// write, read and gate items under several qubit counts. Counts above the
// filled size only touch filled entries. A local predictor keeps its own
// copy of the vector and checks every result field by field.
// ============================================================================
module tb_qubit_gate_state_vector_update;
	import qgsv_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [9:0]  idx;
		logic [15:0] re;
		logic [15:0] im;
		logic [3:0]  tq;
		logic [3:0]  cq;
		logic [31:0] e00;
		logic [31:0] e01;
		logic [31:0] e10;
		logic [31:0] e11;
	} op_t;

	typedef struct {
		logic [15:0] re;
		logic [15:0] im;
		status_t     st;
	} res_t;

	localparam int WATCH_LIMIT = 60000;
	localparam int FILL_QUBITS = 7;
	localparam int FILL_SIZE   = 1 << FILL_QUBITS;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [183:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         cfg_we;
	logic [3:0]   cfg_wdata;

	op_t         pending_ops[$];
	res_t        expected_res[$];
	op_t         cur_op;
	logic [31:0] amp_copy[DEPTH];
	logic [3:0]  qubit_reg;
	int          err_count;
	int          in_gap;
	int          out_gap;
	int          idle_cycles;
	bit          in_taken;
	bit          quiet;

	qubit_gate_state_vector_update u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// Clock with a period of 20.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Effective qubit count after clamping the register value.
	function automatic int eff_qubits();
		int n;
		n = qubit_reg;
		if (n < 1) n = 1;
		if (n > MAX_QUBITS) n = MAX_QUBITS;
		return n;
	endfunction

	// Round an exact product to Q.15 by adding one half and flooring.
	function automatic longint round_q15(longint p);
		return (p + 64'sd16384) >>> 15;
	endfunction

	function automatic logic [15:0] clip16(longint s);
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		return s[15:0];
	endfunction

	function automatic longint hi16(logic [31:0] v);
		return longint'($signed(v[31:16]));
	endfunction

	function automatic longint lo16(logic [31:0] v);
		return longint'($signed(v[15:0]));
	endfunction

	// One output amplitude: e0 * x0 + e1 * x1, complex values packed re:im.
	function automatic logic [31:0] complex_mac(logic [31:0] e0, logic [31:0] x0,
			logic [31:0] e1, logic [31:0] x1);
		longint sr;
		longint si;
		sr = round_q15(hi16(e0) * hi16(x0)) - round_q15(lo16(e0) * lo16(x0))
			+ round_q15(hi16(e1) * hi16(x1)) - round_q15(lo16(e1) * lo16(x1));
		si = round_q15(hi16(e0) * lo16(x0)) + round_q15(lo16(e0) * hi16(x0))
			+ round_q15(hi16(e1) * lo16(x1)) + round_q15(lo16(e1) * hi16(x1));
		return {clip16(sr), clip16(si)};
	endfunction

	// Apply one item to the local vector and return the result it causes.
	function automatic res_t apply_item(op_t op);
		res_t r;
		int n;
		int slots;
		int tb;
		int cb;
		int a;
		logic [31:0] lo;
		logic [31:0] hi;
		n = eff_qubits();
		slots = 1 << n;
		r.re = '0;
		r.im = '0;
		r.st = ST_OK;
		a = int'(op.idx) & (slots - 1);
		if (op.kind == KIND_WRITE) begin
			amp_copy[a] = {op.re, op.im};
		end else if (op.kind == KIND_READ) begin
			r.re = amp_copy[a][31:16];
			r.im = amp_copy[a][15:0];
		end else if (op.tq >= n || (op.kind == KIND_CGATE && op.cq >= n)) begin
			r.st = ST_RANGE;
		end else if (op.kind == KIND_CGATE && op.cq == op.tq) begin
			r.st = ST_SAMEQB;
		end else begin
			tb = 1 << op.tq;
			cb = (op.kind == KIND_CGATE) ? (1 << op.cq) : 0;
			for (int i = 0; i < slots; i++) begin
				if ((i & tb) == 0 && (i & cb) == cb) begin
					lo = amp_copy[i];
					hi = amp_copy[i | tb];
					amp_copy[i] = complex_mac(op.e00, lo, op.e01, hi);
					amp_copy[i | tb] = complex_mac(op.e10, lo, op.e11, hi);
				end
			end
		end
		return r;
	endfunction

	function automatic op_t make_write(int a, logic [15:0] re, logic [15:0] im);
		op_t op;
		op = '{KIND_WRITE, a[9:0], re, im, 4'd0, 4'd0, 0, 0, 0, 0};
		return op;
	endfunction

	function automatic op_t make_gate(kind_t k, int t, int c,
			logic [31:0] e00, logic [31:0] e01, logic [31:0] e10, logic [31:0] e11);
		op_t op;
		op = '{k, 10'($urandom_range(0, 1023)), 16'($urandom), 16'($urandom), t[3:0],
			c[3:0], e00, e01, e10, e11};
		return op;
	endfunction

	// A random matrix entry: half the time full-range, otherwise a unitary-like value.
	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 3))
			0: return 32'h5a82_0000;
			1: return {16'h0000, 16'h5a82};
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_qubit(int n);
		if ($urandom_range(0, 6) == 0) return $urandom_range(0, 15);
		return $urandom_range(0, n - 1);
	endfunction

	// A random item with every field drawn over its full width. Above the
	// filled size, items keep to filled entries and gates leave the vector alone.
	function automatic op_t make_random(int n);
		op_t op;
		int pick;
		pick = $urandom_range(0, 9);
		op = make_gate(KIND_GATE, rand_qubit(n), rand_qubit(n), rand_entry(),
			rand_entry(), rand_entry(), rand_entry());
		if (pick < 3) op.kind = KIND_WRITE;
		else if (pick < 6) op.kind = KIND_READ;
		else if (pick < 8) op.kind = KIND_GATE;
		else op.kind = KIND_CGATE;
		if (n > FILL_QUBITS) begin
			if (op.kind == KIND_WRITE || op.kind == KIND_READ) begin
				op.idx = op.idx & 10'(FILL_SIZE - 1);
			end else if (op.kind == KIND_GATE || $urandom_range(0, 2) == 0) begin
				op.tq = 4'($urandom_range(n, 15));
			end else if ($urandom_range(0, 1) == 0) begin
				op.cq = 4'($urandom_range(n, 15));
			end else begin
				op.cq = op.tq;
			end
		end
		return op;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		err_count++;
	endtask

	// Wait until every item is accepted and every result has come back.
	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_res.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_qubits(logic [3:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		qubit_reg = v;
	endtask

	// Input side: present the next queued item, with random idle bursts.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(0, 13);
				s_axis_tvalid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				cur_op = pending_ops.pop_front();
				// Fields from the low bit up: idx, re, im, tq, cq, e00..e11.
				s_axis_tdata <= 184'({cur_op.e11, cur_op.e10, cur_op.e01, cur_op.e00,
					cur_op.cq, cur_op.tq, cur_op.im, cur_op.re, cur_op.idx});
				s_axis_tuser <= cur_op.kind;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output side: random stall bursts on the ready.
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 13);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Predict on input acceptance, check on output acceptance, watch for hangs.
	always @(posedge clk) begin
		res_t want;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_res.push_back(apply_item(cur_op));
			in_taken = 1'b1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected result", int'(m_axis_tdata[33:0]), 0);
			end else begin
				want = expected_res.pop_front();
				if (m_axis_tdata[15:0] !== want.re)
					report_mismatch("read_re", int'(m_axis_tdata[15:0]), int'(want.re));
				if (m_axis_tdata[31:16] !== want.im)
					report_mismatch("read_im", int'(m_axis_tdata[31:16]), int'(want.im));
				if (m_axis_tdata[33:32] !== want.st)
					report_mismatch("status", int'(m_axis_tdata[33:32]), int'(want.st));
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("tb_qubit_gate_state_vector_update: done, errors");
				$finish;
			end
		end
	end

	// Stimulus: fill the store, directed cases, then random phases.
	initial begin
		logic [3:0] counts[10];
		int n;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		qubit_reg = 4'd10;
		err_count = 0;
		in_gap = 0;
		out_gap = 0;
		idle_cycles = 0;
		in_taken = 1'b0;
		quiet = 1'b0;
		counts = '{4'd10, 4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd4, 4'd7, 4'd6};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// The low entries are written once so no item touches an unwritten one.
		write_qubits(4'(FILL_QUBITS));
		for (int i = 0; i < FILL_SIZE; i++)
			pending_ops.push_back(make_write(i, 16'($urandom), 16'($urandom)));

		// Directed: extremes, index wrap, every kind, each status case.
		pending_ops.push_back(make_write(0, 16'h8000, 16'h7fff));
		pending_ops.push_back(make_write(1023, 16'h7fff, 16'h8000));
		pending_ops.push_back(make_gate(KIND_READ, 0, 0, 0, 0, 0, 0));
		pending_ops[$].idx = 10'd0;
		pending_ops.push_back(make_gate(KIND_READ, 0, 0, 0, 0, 0, 0));
		pending_ops[$].idx = 10'd1023;
		pending_ops.push_back(make_gate(KIND_GATE, 6, 0, 32'h7fff_0000, 0, 0,
			32'h7fff_0000));
		pending_ops.push_back(make_gate(KIND_GATE, 0, 0, 32'h8000_8000, 32'h8000_8000,
			32'h7fff_7fff, 32'h7fff_7fff));
		pending_ops.push_back(make_gate(KIND_GATE, 10, 0, 0, 0, 0, 0));
		pending_ops.push_back(make_gate(KIND_GATE, 15, 0, 0, 0, 0, 0));
		pending_ops.push_back(make_gate(KIND_CGATE, 3, 3, 0, 0, 0, 0));
		pending_ops.push_back(make_gate(KIND_CGATE, 2, 12, 0, 0, 0, 0));
		pending_ops.push_back(make_gate(KIND_CGATE, 15, 15, 0, 0, 0, 0));
		pending_ops.push_back(make_gate(KIND_CGATE, 6, 0, 0, 32'h7fff_0000,
			32'h7fff_0000, 0));
		pending_ops.push_back(make_gate(KIND_CGATE, 0, 6, 32'h5a82_0000, 32'h5a82_0000,
			32'h5a82_0000, 32'ha57e_0000));
		for (int i = 0; i < 6; i++) begin
			pending_ops.push_back(make_gate(KIND_READ, 0, 0, 0, 0, 0, 0));
		end

		// Random phases over several qubit counts; the last runs without idling.
		foreach (counts[p]) begin
			write_qubits(counts[p]);
			n = eff_qubits();
			if (p == 9) quiet = 1'b1;
			for (int i = 0; i < 25; i++) begin
				pending_ops.push_back(make_random(n));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_qubit_gate_state_vector_update: done, clean");
		end else begin
			$display("tb_qubit_gate_state_vector_update: done, errors");
		end
		$finish;
	end

endmodule

### files.f
sv/qgsv_pkg.sv
sv/qgsv_mac.sv
sv/qubit_gate_state_vector_update.sv
sim/tb_qubit_gate_state_vector_update.sv
